### rtl/ppmq_pkg.sv
// ----------------------------------------------------------------------------
// ppmq_pkg: shared types and codes of the pending packet match queue
// Item layouts, command and status codes, and the default store depth.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmq_pkg;

    // Default number of store entries.
    localparam int DEPTH_DEF = 64;

    // Command codes of an input item.
    localparam logic [2:0] KIND_ENQUEUE   = 3'd0;
    localparam logic [2:0] KIND_RELEASE   = 3'd1;
    localparam logic [2:0] KIND_DROP_DEST = 3'd2;
    localparam logic [2:0] KIND_DROP_DEV  = 3'd3;
    localparam logic [2:0] KIND_SHUTDOWN  = 3'd4;

    // Status codes of a result item.
    localparam logic [2:0] STAT_ENQUEUED  = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_SHUT      = 3'd2;
    localparam logic [2:0] STAT_REMOVED   = 3'd3;
    localparam logic [2:0] STAT_NONE      = 3'd4;

    // Input item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] packet_tag;
        logic        post_routing;
        logic [31:0] dest_addr;
        logic        has_in_dev;
        logic [15:0] in_dev;
        logic        has_out_dev;
        logic [15:0] out_dev;
        logic [31:0] match_key;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_tag;
        logic        verdict_drop;
        logic        reroute;
        logic        send_unreachable;
        logic [6:0]  queue_len;
        logic        last;
    } t_out_item;

    // One held packet. Devices pack in_dev, has_in_dev, out_dev, has_out_dev.
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] dest;
        logic        post_routing;
        logic [33:0] devices;
    } t_entry;

endpackage

`default_nettype wire

### rtl/ppmq_store.sv
// ----------------------------------------------------------------------------
// ppmq_store: packet store memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmq_store #(
    parameter int DEPTH = ppmq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire ppmq_pkg::t_entry  i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output      ppmq_pkg::t_entry  o_rdata
);
    import ppmq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/ppmq_match.sv
// ----------------------------------------------------------------------------
// ppmq_match: shared entry compare unit
// Decides whether one held entry is removed by the active command.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmq_match (
    input  wire logic [2:0]        i_kind,
    input  wire logic [31:0]       i_key,
    input  wire ppmq_pkg::t_entry  i_entry,
    output      logic              o_hit
);
    import ppmq_pkg::*;

    logic in_hit;
    logic out_hit;

    // Device compares are over the full key, so wide keys never match.
    assign in_hit  = i_entry.devices[16] && ({16'd0, i_entry.devices[15:0]} == i_key);
    assign out_hit = i_entry.devices[33] && ({16'd0, i_entry.devices[32:17]} == i_key);

    // Select the compare for the command.
    always_comb begin
        unique case (i_kind) inside
            KIND_RELEASE, KIND_DROP_DEST: o_hit = i_entry.post_routing &&
                                                  (i_entry.dest == i_key);
            KIND_DROP_DEV:                o_hit = in_hit || out_hit;
            KIND_SHUTDOWN:                o_hit = 1'b1;
            default:                      o_hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/pending_packet_match_queue.sv
// ----------------------------------------------------------------------------
// pending_packet_match_queue: FIFO of packets waiting for a route
// Enqueues packets and removes them by destination, device or shutdown,
// compacting the store in place while it scans.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+----------------------------
//   input    | i_start, o_busy, i_item       | taken when i_start & !o_busy
//   result   | o_valid, o_result             | one-cycle strobe, no stall
//   config   | i_cfg_we, i_cfg_data          | written when i_cfg_we
//
// An enqueue's result follows in the next cycle; the block stays ready. A
// removal scans the held entries one per cycle through the single read port
// and the shared compare unit, and the block stays busy for the whole scan.
// Each removed entry's result is held until the next match or the end of the
// scan, and the last result leaves in the same cycle that busy drops.
// On an empty store a removal answers in the next cycle without going busy.
// Reset clears the count and terminate flag; the store needs no clearing.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_packet_match_queue #(
    parameter int DEPTH = ppmq_pkg::DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output      logic                o_busy,
    input  wire ppmq_pkg::t_in_item  i_item,
    output      logic                o_valid,
    output      ppmq_pkg::t_out_item o_result,
    input  wire logic                i_cfg_we,
    input  wire logic [6:0]          i_cfg_data
);
    import ppmq_pkg::*;

    localparam int         AW      = $clog2(DEPTH);
    localparam int         CW      = $clog2(DEPTH + 1);
    localparam logic [6:0] DEPTH_L = 7'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic            r_term, n_term;
    logic [6:0]      r_max_len;
    logic [2:0]      r_kind, n_kind;
    logic [31:0]     r_key, n_key;
    logic [AW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_wr, n_wr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_have_pend, n_have_pend;
    t_out_item       r_pend, n_pend;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic            we;
    logic [AW-1:0]   waddr;
    t_entry          wdata;
    logic [AW-1:0]   raddr;
    t_entry          rdata;
    logic            hit;
    logic [6:0]      limit;
    logic            scan_end;

    ppmq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ppmq_match u_match (
        .i_kind  (r_kind),
        .i_key   (r_key),
        .i_entry (rdata),
        .o_hit   (hit)
    );

    // Effective bound on held packets.
    assign limit    = (r_max_len < DEPTH_L) ? r_max_len : DEPTH_L;
    assign scan_end = ((CW'(r_idx) + CW'(1)) == r_fill);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_term      = r_term;
        n_kind      = r_kind;
        n_key       = r_key;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_cnt       = r_cnt;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;
        n_out_valid = 1'b0;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_wr[AW-1:0];
        wdata       = rdata;
        raddr       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_item.kind) inside
                        KIND_ENQUEUE: begin
                            n_out_valid      = 1'b1;
                            n_out            = '0;
                            n_out.out_tag    = i_item.packet_tag;
                            n_out.queue_len  = 7'(r_fill);
                            n_out.last       = 1'b1;
                            if (7'(r_fill) >= limit) begin
                                n_out.status = STAT_FULL;
                            end else if (r_term) begin
                                n_out.status = STAT_SHUT;
                            end else begin
                                we                 = 1'b1;
                                waddr              = r_fill[AW-1:0];
                                wdata.tag          = i_item.packet_tag;
                                wdata.dest         = i_item.dest_addr;
                                wdata.post_routing = i_item.post_routing;
                                wdata.devices      = {i_item.has_out_dev, i_item.out_dev,
                                                      i_item.has_in_dev, i_item.in_dev};
                                n_fill             = r_fill + CW'(1);
                                n_out.status       = STAT_ENQUEUED;
                                n_out.queue_len    = 7'(r_fill + CW'(1));
                            end
                        end
                        KIND_RELEASE, KIND_DROP_DEST, KIND_DROP_DEV, KIND_SHUTDOWN: begin
                            if (i_item.kind == KIND_SHUTDOWN) begin
                                n_term = 1'b1;
                            end
                            n_kind      = i_item.kind;
                            n_key       = i_item.match_key;
                            n_idx       = '0;
                            n_wr        = '0;
                            n_cnt       = r_fill;
                            n_have_pend = 1'b0;
                            if (r_fill == '0) begin
                                n_out_valid  = 1'b1;
                                n_out        = '0;
                                n_out.status = STAT_NONE;
                                n_out.last   = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // Unknown commands are ignored.
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Fetch the next entry while the current one is compared.
                raddr = r_idx + AW'(1);
                n_idx = r_idx + AW'(1);
                if (hit) begin
                    // The previous match is known not to be the final one.
                    if (r_have_pend) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                    end
                    n_cnt                   = r_cnt - CW'(1);
                    n_have_pend             = 1'b1;
                    n_pend.status           = STAT_REMOVED;
                    n_pend.out_tag          = rdata.tag;
                    n_pend.verdict_drop     = (r_kind != KIND_RELEASE);
                    n_pend.reroute          = (r_kind == KIND_RELEASE);
                    n_pend.send_unreachable = (r_kind == KIND_DROP_DEST);
                    n_pend.queue_len        = 7'(r_cnt - CW'(1));
                    n_pend.last             = 1'b0;
                end else begin
                    // Kept entries slide down over removed ones.
                    we   = 1'b1;
                    n_wr = r_wr + CW'(1);
                end
                if (scan_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_fill      = r_wr;
                n_out_valid = 1'b1;
                if (r_have_pend) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                end else begin
                    n_out           = '0;
                    n_out.status    = STAT_NONE;
                    n_out.queue_len = 7'(r_wr);
                    n_out.last      = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_term      <= 1'b0;
            r_max_len   <= 7'd64;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_term      <= n_term;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    // Scan and payload registers.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_wr   <= n_wr;
        r_cnt  <= n_cnt;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the pending packet match queue
// A clocked driver feeds command items from a pending queue, with random
// bursts of idle cycles, and a clocked monitor checks every result strobe
// against a shadow queue model kept in step with each accepted item.
// The run walks through several max_len settings, from zero to above the
// store depth, and ends with the shutdown behavior, which is sticky.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmq_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam int          RESET_CYCLES  = 11;
    localparam int          DRAIN_CYCLES  = DEPTH_DEF + 8;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam logic [2:0]  KIND_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  KIND_LAST_CODE    = 3'd7;

    // Block ports; every input is known from time zero.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_start    = 1'b0;
    logic        o_busy;
    t_in_item    i_item     = '0;
    logic        o_valid;
    t_out_item   o_result;
    logic        i_cfg_we   = 1'b0;
    logic [6:0]  i_cfg_data = 7'd64;

    // Stimulus and checking state.
    t_in_item    pending_items[$];
    t_out_item   expected_results[$];
    int unsigned items_in_flight = 0;
    logic        item_taken      = 1'b0;
    int unsigned gap_left        = 0;
    int unsigned idle_chance     = 0;
    int unsigned cycle_count     = 0;
    int unsigned fail_count      = 0;

    // Shadow copy of the queue contents, its terminate flag and its max_len register.
    t_entry      shadow_store[$];
    logic        shadow_terminated = 1'b0;
    logic [6:0]  shadow_max_len    = 7'd64;

    // Run statistics for the closing summary.
    int unsigned n_enqueue = 0, n_removal = 0, n_shutdown = 0, n_ignored = 0;
    int unsigned n_results = 0, n_full = 0, n_shut = 0, n_none = 0, n_removed = 0;
    int unsigned peak_fill = 0;

    pending_packet_match_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // True if a held entry is selected by a removal command.
    function automatic logic entry_selected(logic [2:0] kind, t_entry e, logic [31:0] key);
        case (kind) inside
            KIND_RELEASE, KIND_DROP_DEST: begin
                return e.post_routing && (e.dest == key);
            end
            KIND_DROP_DEV: begin
                return (e.devices[16] && ({16'd0, e.devices[15:0]} == key)) ||
                       (e.devices[33] && ({16'd0, e.devices[32:17]} == key));
            end
            default: begin
                return 1'b1;
            end
        endcase
    endfunction

    // Apply one accepted item to the shadow queue and queue its results.
    function automatic void predict_queue_op(t_in_item it);
        int unsigned limit_now;
        int unsigned remaining;
        t_entry      kept[$];
        t_out_item   res;
        t_out_item   held_back;
        logic        have_held;

        limit_now = (shadow_max_len < DEPTH_DEF) ? shadow_max_len : DEPTH_DEF;
        res = '0;
        res.out_tag = it.packet_tag;
        res.last = 1'b1;

        if (it.kind == KIND_ENQUEUE) begin
            n_enqueue++;
            if (shadow_store.size() >= limit_now) begin
                res.status = STAT_FULL;
            end else if (shadow_terminated) begin
                res.status = STAT_SHUT;
            end else begin
                shadow_store.push_back('{tag: it.packet_tag, dest: it.dest_addr,
                    post_routing: it.post_routing,
                    devices: {it.has_out_dev, it.out_dev, it.has_in_dev, it.in_dev}});
                res.status = STAT_ENQUEUED;
            end
            res.queue_len = 7'(shadow_store.size());
            expected_results.push_back(res);
            return;
        end
        if (it.kind > KIND_SHUTDOWN) begin
            n_ignored++;
            return;
        end

        if (it.kind == KIND_SHUTDOWN) begin
            shadow_terminated = 1'b1;
            n_shutdown++;
        end else begin
            n_removal++;
        end

        // Scan oldest to newest; a result is held back until the next one
        // shows whether it is the final result of the item.
        remaining = shadow_store.size();
        have_held = 1'b0;
        held_back = '0;
        foreach (shadow_store[i]) begin
            if (entry_selected(it.kind, shadow_store[i], it.match_key)) begin
                remaining--;
                if (have_held) expected_results.push_back(held_back);
                held_back = '0;
                held_back.status           = STAT_REMOVED;
                held_back.out_tag          = shadow_store[i].tag;
                held_back.verdict_drop     = (it.kind != KIND_RELEASE);
                held_back.reroute          = (it.kind == KIND_RELEASE);
                held_back.send_unreachable = (it.kind == KIND_DROP_DEST);
                held_back.queue_len        = 7'(remaining);
                have_held = 1'b1;
            end else begin
                kept.push_back(shadow_store[i]);
            end
        end
        shadow_store = kept;

        if (have_held) begin
            held_back.last = 1'b1;
            expected_results.push_back(held_back);
        end else begin
            res.status = STAT_NONE;
            res.out_tag = '0;
            res.queue_len = 7'(shadow_store.size());
            expected_results.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s = 0x%0h, expected 0x%0h",
                                      n_results, name, got, want));
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: status %0d tag 0x%0h",
                                      got.status, got.out_tag));
            return;
        end
        want = expected_results.pop_front();
        check_field("status",       32'(got.status),       32'(want.status));
        check_field("out_tag",      32'(got.out_tag),      32'(want.out_tag));
        check_field("verdict_drop", 32'(got.verdict_drop), 32'(want.verdict_drop));
        check_field("reroute",      32'(got.reroute),      32'(want.reroute));
        check_field("send_unreachable", 32'(got.send_unreachable),
                    32'(want.send_unreachable));
        check_field("queue_len",    32'(got.queue_len),    32'(want.queue_len));
        check_field("last",         32'(got.last),         32'(want.last));
        n_results++;
        case (want.status)
            STAT_FULL:    n_full++;
            STAT_SHUT:    n_shut++;
            STAT_NONE:    n_none++;
            STAT_REMOVED: n_removed++;
            default: ;
        endcase
        if (32'(want.queue_len) > peak_fill) peak_fill = 32'(want.queue_len);
    endtask

    // Monitor: register writes, result strobes and item acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) shadow_max_len = i_cfg_data;
            if (o_valid === 1'b1) check_result(o_result);
            if (i_start && !o_busy) begin
                predict_queue_op(i_item);
                items_in_flight--;
            end
            item_taken <= i_start && !o_busy;
        end else begin
            item_taken <= 1'b0;
        end
    end

    // Driver: present the next pending item, with random idle bursts.
    always @(negedge i_clk) begin
        logic     next_start;
        t_in_item next_item;
        next_start = i_start;
        next_item  = i_item;
        if (item_taken) begin
            next_start = 1'b0;
            if ($urandom_range(1, 100) <= idle_chance) gap_left = $urandom_range(1, 15);
        end
        if (!next_start) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                next_item  = pending_items.pop_front();
                next_start = 1'b1;
            end
        end
        i_start <= next_start;
        i_item  <= next_item;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_item(t_in_item it);
        pending_items.push_back(it);
        items_in_flight++;
    endtask

    function automatic t_in_item mk(logic [2:0] kind, logic [15:0] tag, logic post,
                                    logic [31:0] dest, logic hin, logic [15:0] indev,
                                    logic hout, logic [15:0] outdev, logic [31:0] key);
        return '{kind: kind, packet_tag: tag, post_routing: post, dest_addr: dest,
                 has_in_dev: hin, in_dev: indev, has_out_dev: hout, out_dev: outdev,
                 match_key: key};
    endfunction

    // A small address pool makes destination matches common.
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hC0A8_0001;
            3: return 32'h0A00_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_dev();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h0002;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_item(logic [2:0] kind);
        t_in_item it;
        it.kind         = kind;
        it.packet_tag   = 16'($urandom);
        it.post_routing = ($urandom_range(0, 3) != 0);
        it.dest_addr    = pick_addr();
        it.has_in_dev   = 1'($urandom_range(0, 1));
        it.in_dev       = pick_dev();
        it.has_out_dev  = 1'($urandom_range(0, 1));
        it.out_dev      = pick_dev();
        if (kind == KIND_DROP_DEV)
            it.match_key = ($urandom_range(0, 7) == 0) ? $urandom : {16'd0, pick_dev()};
        else if (kind == KIND_ENQUEUE)
            it.match_key = $urandom;
        else
            it.match_key = pick_addr();
        return it;
    endfunction

    // Block until every item is taken, all results are in and the block
    // is idle, then wait out the DRAIN_CYCLES margin.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (items_in_flight != 0 || expected_results.size() != 0 || o_busy);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_max_len(logic [6:0] value);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Enqueue bursts, sometimes long enough to fill the store, each closed
    // by a removal; now and then an unused command code slips in.
    task automatic run_random_phase(logic [6:0] limit_setting, int unsigned n_items,
                                    int unsigned idle_pct);
        int unsigned done_items;
        int unsigned burst;
        set_max_len(limit_setting);
        idle_chance = idle_pct;
        done_items = 0;
        while (done_items < n_items) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 12);
            repeat (burst) queue_item(make_item(KIND_ENQUEUE));
            done_items += burst;
            if ($urandom_range(0, 9) == 0)
                queue_item(make_item(3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_CODE))));
            queue_item(make_item(3'($urandom_range(KIND_RELEASE, KIND_DROP_DEV))));
            done_items++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset setting of max_len.
        idle_chance = 30;
        queue_item(mk(KIND_RELEASE, 16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0, 32'h0));
        queue_item(mk(KIND_ENQUEUE, 16'h0000, 1'b1, 32'h0000_0000, 1'b0, 16'h0000,
                      1'b0, 16'h0000, 32'h0));
        queue_item(mk(KIND_ENQUEUE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF,
                      1'b1, 16'hFFFF, 32'hFFFF_FFFF));
        // Same destination as the first entry, but not queued at post-routing.
        queue_item(mk(KIND_ENQUEUE, 16'h1234, 1'b0, 32'h0000_0000, 1'b1, 16'h0005,
                      1'b0, 16'h0005, 32'h0));
        queue_item(mk(KIND_ENQUEUE, 16'h0002, 1'b1, 32'h0A00_0001, 1'b0, 16'h0007,
                      1'b1, 16'h0009, 32'h0));
        queue_item(mk(KIND_ENQUEUE, 16'h0003, 1'b1, 32'h0000_0000, 1'b0, 16'h0000,
                      1'b0, 16'h0000, 32'h0));
        queue_item(mk(KIND_ENQUEUE, 16'h0004, 1'b1, 32'h0B00_0000, 1'b0, 16'h0009,
                      1'b1, 16'h0009, 32'h0));
        // Device index present only as a stale value, never a match.
        queue_item(mk(KIND_ENQUEUE, 16'h0005, 1'b0, 32'h0B00_0000, 1'b0, 16'h0009,
                      1'b0, 16'h0009, 32'h0));
        queue_item(mk(KIND_RELEASE,   16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'h0000_0000));
        queue_item(mk(KIND_DROP_DEST, 16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'h0A00_0001));
        queue_item(mk(KIND_DROP_DEST, 16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'h0000_3039));
        // Key above the device range with matching low bits: no match.
        queue_item(mk(KIND_DROP_DEV,  16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'h0001_FFFF));
        queue_item(mk(KIND_DROP_DEV,  16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'h0000_0009));
        queue_item(mk(KIND_DROP_DEV,  16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'h0000_FFFF));
        queue_item(mk(KIND_DROP_DEV,  16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'h0000_0005));
        queue_item(mk(KIND_FIRST_UNUSED, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF,
                      1'b1, 16'hFFFF, 32'hFFFF_FFFF));
        queue_item(make_item(3'(KIND_FIRST_UNUSED + 3'd1)));
        queue_item(make_item(KIND_LAST_CODE));
        queue_item(mk(KIND_RELEASE,   16'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 16'h0,
                      32'hFFFF_FFFF));

        // Random part over a range of limits, the extremes among them.
        run_random_phase(7'd127, 50, 30);
        run_random_phase(7'd9,   35, 0);
        run_random_phase(7'd0,   10, 40);
        run_random_phase(7'd1,   20, 20);
        run_random_phase(7'd64,  50, 25);
        run_random_phase(7'd100, 25, 0);
        run_random_phase(7'($urandom_range(2, 63)), 45, 30);

        // Shutdown is sticky, so it closes the run; no idling from here on.
        set_max_len(7'd3);
        idle_chance = 0;
        repeat (5) queue_item(make_item(KIND_ENQUEUE));
        queue_item(make_item(KIND_SHUTDOWN));
        queue_item(make_item(KIND_SHUTDOWN));
        queue_item(make_item(KIND_ENQUEUE));
        queue_item(make_item(KIND_RELEASE));
        // With a zero limit the full check wins over the shutdown.
        set_max_len(7'd0);
        queue_item(make_item(KIND_ENQUEUE));
        set_max_len(7'd127);
        repeat (12) queue_item(make_item(3'($urandom_range(KIND_ENQUEUE, KIND_LAST_CODE))));
        wait_quiet();

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        $display("Items: %0d enqueues, %0d removals, %0d shutdowns, %0d ignored codes",
                 n_enqueue, n_removal, n_shutdown, n_ignored);
        $display("Results: %0d checked, %0d removed, %0d full, %0d shut, %0d empty; peak fill %0d",
                 n_results, n_removed, n_full, n_shut, n_none, peak_fill);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
